// File: rtl/rpd_pkg.sv
// Package: field widths, character codes and the character class struct of the RLE run decoder.
`timescale 1ns / 1ps

package rpd_pkg;

  localparam int CharWidth  = 8;
  localparam int CoordWidth = 16;
  localparam int DigitWidth = 4;

  typedef logic [CharWidth-1:0]  char_t;
  typedef logic [CoordWidth-1:0] coord_t;
  typedef logic [DigitWidth-1:0] digit_t;

  localparam char_t ChBang   = 8'h21;  // '!'
  localparam char_t ChDead   = 8'h62;  // 'b'
  localparam char_t ChLive   = 8'h6F;  // 'o'
  localparam char_t ChEol    = 8'h24;  // '$'
  localparam char_t ChHash   = 8'h23;  // '#'
  localparam char_t ChHeader = 8'h78;  // 'x'
  localparam char_t ChZero   = 8'h30;  // '0'
  localparam char_t ChNine   = 8'h39;  // '9'
  localparam char_t ChSpace  = 8'h20;
  localparam char_t ChTab    = 8'h09;
  localparam char_t ChLf     = 8'h0A;
  localparam char_t ChVt     = 8'h0B;
  localparam char_t ChFf     = 8'h0C;
  localparam char_t ChCr     = 8'h0D;

  typedef struct packed {
    logic   is_digit;
    logic   is_bang;
    logic   is_blank;
    logic   is_dead;
    logic   is_eol;
    logic   is_live;
    logic   is_header;
    digit_t digit;
  } char_class_t;

endpackage

// File: rtl/rpd_if.sv
// Interfaces: character input channel and live run output channel.
`timescale 1ns / 1ps

interface rpd_char_if import rpd_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t ch;
  logic  line_start;
  logic  pattern_start;

  modport source (output valid, ch, line_start, pattern_start, input ready);
  modport sink   (input valid, ch, line_start, pattern_start, output ready);
endinterface

interface rpd_run_if import rpd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t run_x;
  coord_t run_y;
  coord_t run_length;

  modport source (output valid, run_x, run_y, run_length, input ready);
  modport sink   (input valid, run_x, run_y, run_length, output ready);
endinterface

// File: rtl/rpd_char_class.sv
// Character classifier: decodes one pattern character into class flags and a digit value.
`timescale 1ns / 1ps

module rpd_char_class import rpd_pkg::*; (
  input  char_t       ch,
  output char_class_t cls
);

  char_t digit_off;

  assign digit_off = ch - ChZero;

  always_comb begin
    cls.is_digit  = (ch >= ChZero) && (ch <= ChNine);
    cls.is_bang   = (ch == ChBang);
    cls.is_blank  = (ch == ChSpace) || (ch == ChTab) || (ch == ChLf) ||
                    (ch == ChVt) || (ch == ChFf) || (ch == ChCr);
    cls.is_dead   = (ch == ChDead);
    cls.is_eol    = (ch == ChEol);
    cls.is_live   = (ch == ChLive);
    cls.is_header = (ch == ChHash) || (ch == ChHeader);
    cls.digit     = digit_off[DigitWidth-1:0];
  end

endmodule

// File: rtl/rle_pattern_run_decoder_unit.sv
// Top level: RLE cell pattern decoder that turns a character stream into live runs.
`timescale 1ns / 1ps

// The decoder takes one character beat per clock and returns a beat for each
// live run ('o') it sees, carrying the run's column, row and length. A beat
// in passes through an input register, is decoded and applied to the
// position and count state as it leaves that register, and any run it causes
// is loaded into the output register on the same edge as that state update.
// Throughput is one character per cycle; the only thing that slows intake is
// a run waiting in the output register while the sink holds ready low, which
// stalls the decode stage and then the input register.
// Header and comment lines (first character '#' or 'x') are skipped, and
// everything after '!' is ignored until a beat with pattern_start arrives.

module rle_pattern_run_decoder_unit import rpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rpd_char_if.sink   chars,
  rpd_run_if.source  runs
);

  // Input register
  logic  q_valid;
  char_t q_ch;
  logic  q_ls;
  logic  q_ps;

  // Decoder state
  coord_t col_pos;
  coord_t row_pos;
  coord_t count_acc;
  logic   have_digits;
  logic   skip_line;
  logic   pattern_done;

  coord_t col_pos_next;
  coord_t row_pos_next;
  coord_t count_acc_next;
  logic   have_digits_next;
  logic   skip_line_next;
  logic   pattern_done_next;

  // Output register
  logic   out_valid;
  coord_t out_x;
  coord_t out_y;
  coord_t out_len;

  char_class_t cls;
  logic        advance;
  logic        commit;
  logic        emit;
  logic        line_begin;
  logic        active;
  coord_t      col_base;
  coord_t      row_base;
  coord_t      cnt_base;
  logic        hd_base;
  coord_t      run_n;
  coord_t      cnt_times_ten;

  rpd_char_class u_class (
    .ch  (q_ch),
    .cls (cls)
  );

  // The decode stage moves whenever the output register can take a beat.
  assign advance      = !out_valid || runs.ready;
  assign commit       = q_valid && advance;
  assign chars.ready  = !q_valid || advance;

  always_comb begin
    // A pattern start clears position and end flag and counts as a line start.
    line_begin = q_ls || q_ps;
    col_base   = q_ps ? '0 : col_pos;
    row_base   = q_ps ? '0 : row_pos;
    cnt_base   = line_begin ? '0 : count_acc;
    hd_base    = line_begin ? 1'b0 : have_digits;

    skip_line_next    = line_begin ? cls.is_header : skip_line;
    pattern_done_next = q_ps ? 1'b0 : pattern_done;
    active            = !pattern_done_next && !skip_line_next;

    col_pos_next     = col_base;
    row_pos_next     = row_base;
    count_acc_next   = cnt_base;
    have_digits_next = hd_base;

    // count * 10 as two shifts and an add, wrapping at 16 bits
    cnt_times_ten = (cnt_base << 3) + (cnt_base << 1);
    run_n         = hd_base ? cnt_base : coord_t'(1);
    emit          = 1'b0;

    if (active) begin
      if (cls.is_digit) begin
        count_acc_next   = cnt_times_ten + coord_t'(cls.digit);
        have_digits_next = 1'b1;
      end else if (cls.is_bang) begin
        count_acc_next    = '0;
        have_digits_next  = 1'b0;
        pattern_done_next = 1'b1;
      end else if (cls.is_blank) begin
        count_acc_next   = '0;
        have_digits_next = 1'b0;
      end else if (cls.is_dead) begin
        col_pos_next     = col_base + run_n;
        count_acc_next   = '0;
        have_digits_next = 1'b0;
      end else if (cls.is_eol) begin
        col_pos_next     = '0;
        row_pos_next     = row_base + run_n;
        count_acc_next   = '0;
        have_digits_next = 1'b0;
      end else if (cls.is_live) begin
        count_acc_next   = '0;
        have_digits_next = 1'b0;
        // an explicit zero count gives no run
        if (run_n != '0) begin
          emit         = 1'b1;
          col_pos_next = col_base + run_n;
        end
      end
    end
  end

  // Input register: load on each accepted beat, drain into the decode stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (chars.ready) begin
      q_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      q_ch <= chars.ch;
      q_ls <= chars.line_start;
      q_ps <= chars.pattern_start;
    end
  end

  // Decoder state: update only when the held character is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos      <= '0;
      row_pos      <= '0;
      count_acc    <= '0;
      have_digits  <= 1'b0;
      skip_line    <= 1'b0;
      pattern_done <= 1'b0;
    end else if (commit) begin
      col_pos      <= col_pos_next;
      row_pos      <= row_pos_next;
      count_acc    <= count_acc_next;
      have_digits  <= have_digits_next;
      skip_line    <= skip_line_next;
      pattern_done <= pattern_done_next;
    end
  end

  // Output register: hold a run until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= commit && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && emit) begin
      out_x   <= col_base;
      out_y   <= row_base;
      out_len <= run_n;
    end
  end

  assign runs.valid      = out_valid;
  assign runs.run_x      = out_x;
  assign runs.run_y      = out_y;
  assign runs.run_length = out_len;

  // A run beat never carries length zero.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_len != '0))
    else $error("run beat with zero length");

  // With the output register empty, intake never stalls.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> chars.ready)
    else $error("input stalled with empty output register");

  // A consumed '!' on a live line ends the pattern.
  a_bang_ends: assert property (@(posedge clk) disable iff (rst)
    (commit && active && cls.is_bang) |=> pattern_done)
    else $error("end flag not set after bang");

  // A run on the first character of a pattern starts at the origin.
  a_start_origin: assert property (@(posedge clk) disable iff (rst)
    (commit && emit && q_ps) |=> (out_valid && out_x == '0 && out_y == '0))
    else $error("first run of a pattern not at origin");

endmodule

// File: sim/rpd_run_scoreboard_pkg.sv
// Scoreboard class: predicts live runs from accepted characters and checks returned runs.
`timescale 1ns / 1ps

package rpd_run_scoreboard_pkg;
  import rpd_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t len;
  } live_run_t;

  class run_scoreboard;
    coord_t      col;
    coord_t      row;
    coord_t      count;
    bit          have_count;
    bit          in_skip;
    bit          ended;
    live_run_t   runs_due[$];
    int          errors;

    function new();
      col        = '0;
      row        = '0;
      count      = '0;
      have_count = 1'b0;
      in_skip    = 1'b0;
      ended      = 1'b0;
      errors     = 0;
    endfunction

    function int pending();
      return runs_due.size();
    endfunction

    // Advance the decoder state by one accepted character; queue any run it yields.
    function void note_char(char_t c, logic ls, logic ps);
      coord_t    n;
      logic      lstart;
      live_run_t r;
      int        wide;
      lstart = ls;
      if (ps) begin
        col    = '0;
        row    = '0;
        ended  = 1'b0;
        lstart = 1'b1;
      end
      if (lstart) begin
        count      = '0;
        have_count = 1'b0;
        in_skip    = (c == ChHash) || (c == ChHeader);
      end
      if (ended || in_skip) return;

      if (c >= ChZero && c <= ChNine) begin
        wide       = int'(count) * 10 + int'(c - ChZero);
        count      = coord_t'(wide);
        have_count = 1'b1;
        return;
      end
      if (c == ChBang) begin
        count      = '0;
        have_count = 1'b0;
        ended      = 1'b1;
        return;
      end
      if (c inside {ChSpace, ChTab, ChLf, ChVt, ChFf, ChCr}) begin
        count      = '0;
        have_count = 1'b0;
        return;
      end

      n = have_count ? count : coord_t'(1);
      if (c == ChDead) begin
        col        = col + n;
        count      = '0;
        have_count = 1'b0;
      end else if (c == ChEol) begin
        col        = '0;
        row        = row + n;
        count      = '0;
        have_count = 1'b0;
      end else if (c == ChLive) begin
        count      = '0;
        have_count = 1'b0;
        if (n != 0) begin
          r.x   = col;
          r.y   = row;
          r.len = n;
          runs_due = {runs_due, r};
          col = col + n;
        end
      end
    endfunction

    // Compare one returned run with the oldest predicted one.
    function void check_run(coord_t x, coord_t y, coord_t len);
      live_run_t r;
      if (runs_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected run x=%0d y=%0d length=%0d", $time, x, y, len);
        return;
      end
      r = runs_due.pop_front();
      if (x !== r.x) begin
        errors++;
        $display("%0t: run_x expected %0d actual %0d", $time, r.x, x);
      end
      if (y !== r.y) begin
        errors++;
        $display("%0t: run_y expected %0d actual %0d", $time, r.y, y);
      end
      if (len !== r.len) begin
        errors++;
        $display("%0t: run_length expected %0d actual %0d", $time, r.len, len);
      end
    endfunction
  endclass

endpackage

// File: sim/tb_top.sv
// Testbench top: drives RLE text into the run decoder and checks every live run it returns.
`timescale 1ns / 1ps

// Characters go in as beats on the chars channel; every accepted beat is fed
// to the scoreboard, which predicts the run (if any) that beat must produce.
// Runs coming back on the runs channel are checked in order against those
// predictions. The stimulus opens with a few hand-written lines that hit the
// corner cases (skipped header and comment lines, explicit zero counts, count
// overflow, ignored characters inside a count, '!' ending the pattern), then
// runs mostly well-formed random patterns mixed with bursts of raw noise.
// The random part walks through four idling phases, and once holds the run
// sink off long enough that the decoder backs up and stalls its input.

module tb_top;
  import rpd_pkg::*;
  import rpd_run_scoreboard_pkg::*;

  localparam int TotalChars  = 950;
  localparam int HoldCycles  = 300;   // long sink hold-off
  localparam int QuietLimit  = 2000;  // cycles with no beat on either side
  localparam int TailCycles  = 20;    // settle time after the last run

  logic clk = 1'b0;
  logic rst;

  rpd_char_if chars ();
  rpd_run_if  runs ();

  rle_pattern_run_decoder_unit dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .runs  (runs)
  );

  run_scoreboard board = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int chars_sent     = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  bit start_pending  = 1'b0;

  always #4 clk = ~clk;

  // Run sink: check each accepted run, then pick ready for the next edge.
  // A hold-off request from the stimulus holds ready low while a countdown, loaded from HoldCycles, runs down.
  always @(posedge clk) begin
    if (rst) begin
      runs.ready <= 1'b0;
    end else begin
      if (runs.valid && runs.ready) begin
        board.check_run(runs.run_x, runs.run_y, runs.run_length);
      end
      if (hold_left > 0) begin
        runs.ready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
        hold_served <= hold_asked;
        hold_left   <= HoldCycles;
        runs.ready  <= 1'b0;
      end else begin
        runs.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((chars.valid && chars.ready) || (runs.valid && runs.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one character beat, idling first as the sender phase asks; hold
  // valid and the payload until the beat is taken, then note it.
  task automatic send_char(char_t c, logic ls, logic ps);
    while ($urandom_range(99) < send_idle_pct) begin
      chars.valid <= 1'b0;
      @(posedge clk);
    end
    chars.valid         <= 1'b1;
    chars.ch            <= c;
    chars.line_start    <= ls;
    chars.pattern_start <= ps;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    board.note_char(c, ls, ps);
    chars_sent++;
  endtask

  // Send one character, flagging pattern start on the first one of a pattern.
  task automatic emit(char_t c, logic ls);
    send_char(c, ls, start_pending);
    start_pending = 1'b0;
  endtask

  task automatic send_line(string s, logic ps);
    for (int i = 0; i < s.len(); i++) begin
      send_char(char_t'(s[i]), i == 0, ps && (i == 0));
    end
  endtask

  function automatic char_t blank_char();
    case ($urandom_range(5))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChLf;
      3:       return ChVt;
      4:       return ChFf;
      default: return ChCr;
    endcase
  endfunction

  function automatic char_t digit_char();
    return ChZero + char_t'($urandom_range(9));
  endfunction

  // Header or comment line: first character marks it, the rest is arbitrary.
  task automatic send_skipped_line();
    int n;
    n = $urandom_range(1, 10);
    emit(($urandom_range(1) == 0) ? ChHash : ChHeader, 1'b1);
    for (int i = 1; i < n; i++) begin
      emit(char_t'($urandom_range(255)), 1'b0);
    end
  endtask

  // Body line: a run of tokens, each an optional count and a tag, with the
  // odd blank or stray character between them.
  task automatic send_body_line();
    int ntok;
    int r;
    int ndig;
    bit first;
    ntok  = $urandom_range(1, 8);
    first = 1'b1;
    for (int t = 0; t < ntok; t++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        emit(blank_char(), first);
        first = 1'b0;
      end else if (r < 9) begin
        emit(char_t'($urandom_range(255)), first);
        first = 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 25)      ndig = 0;
        else if (r < 65) ndig = 1;
        else if (r < 85) ndig = 2;
        else if (r < 95) ndig = 3;
        else             ndig = $urandom_range(5, 6);
        for (int d = 0; d < ndig; d++) begin
          emit(digit_char(), first);
          first = 1'b0;
        end
        r = $urandom_range(99);
        emit((r < 50) ? ChLive : (r < 80) ? ChDead : ChEol, first);
        first = 1'b0;
      end
    end
  endtask

  // One random pattern: optional header lines, body lines, usually a '!'
  // and sometimes trailing text that must be ignored.
  task automatic send_pattern();
    int nlines;
    start_pending = 1'b1;
    while ($urandom_range(2) == 0) send_skipped_line();
    nlines = $urandom_range(1, 6);
    for (int l = 0; l < nlines; l++) begin
      if ($urandom_range(9) == 0) send_skipped_line();
      else                        send_body_line();
    end
    if ($urandom_range(4) != 0) begin
      emit(ChBang, 1'b0);
      for (int i = $urandom_range(3); i > 0; i--) begin
        emit(($urandom_range(1) == 0) ? ChLive : char_t'($urandom_range(255)),
             $urandom_range(1) == 0);
      end
    end
  endtask

  // Raw noise: any byte, random line and pattern start flags.
  task automatic send_noise();
    for (int i = $urandom_range(1, 8); i > 0; i--) begin
      send_char(char_t'($urandom_range(255)), $urandom_range(1) == 0,
                $urandom_range(9) == 0);
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    chars.valid         <= 1'b0;
    chars.ch            <= '0;
    chars.line_start    <= 1'b0;
    chars.pattern_start <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines: comment and header skipped, zero counts, overflow,
    // stray bytes inside a count, '!' then an ignored live cell.
    send_line("#C", 1'b1);
    send_line("x=", 1'b0);
    send_line("o0o0b", 1'b0);
    send_line("70000o", 1'b0);
    send_char(8'hFF, 1'b1, 1'b0);
    send_char(ChZero + 8'd3, 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(ChZero + 8'd4, 1'b0, 1'b0);
    send_char(ChLive, 1'b0, 1'b0);
    send_line("0$ o!o", 1'b0);

    // Random part; hold the sink off once early so the decoder backs up.
    hold_asked++;
    while (chars_sent < TotalChars) begin
      case (chars_sent * 4 / TotalChars)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
      endcase
      if ($urandom_range(99) < 12) send_noise();
      else                         send_pattern();
    end
    chars.valid <= 1'b0;

    // Drain the predicted runs, then let any stray beat surface.
    recv_stall_pct = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rpd_pkg.sv
rtl/rpd_if.sv
rtl/rpd_char_class.sv
rtl/rle_pattern_run_decoder_unit.sv
sim/rpd_run_scoreboard_pkg.sv
sim/tb_top.sv
